[rtl/kms_pkg.sv]
// shared types, constants and helper functions of the keypad matrix scanner
`default_nettype none

package kms_pkg;

    // default matrix size
    localparam int ROW_COUNT_DEF    = 4;
    localparam int COLUMN_COUNT_DEF = 4;

    // widths of the fixed payload fields
    localparam int LEVELS_W    = 4;
    localparam int ROW_OUT_W   = 2;
    localparam int DRIVE_W     = 4;
    localparam int ROW_KEYS_W  = 8;
    localparam int ALL_KEYS_W  = 32;
    localparam int COUNT_W     = 5;
    localparam int DOWN_CNT_W  = 3;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // most keys reported per row and over the whole matrix
    localparam int ROW_KEYS_MAX = ROW_KEYS_W / 2;
    localparam int ALL_KEYS_MAX = ALL_KEYS_W / 2;

    // register word index (paddr[2])
    localparam logic [0:0] REG_SCANNER_ENABLED = 1'b0;

    // status codes
    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_NOT_ENABLED = 1'b1;

    typedef enum logic [1:0] {
        KC_IDLE     = 2'd0,
        KC_PRESSED  = 2'd1,
        KC_HELD     = 2'd2,
        KC_RELEASED = 2'd3
    } t_key_class;

    typedef struct packed {
        logic [ROW_OUT_W-1:0]  row_scanned;
        logic [DRIVE_W-1:0]    next_row_drive;
        logic [ROW_KEYS_W-1:0] row_key_states;
        logic [ALL_KEYS_W-1:0] all_key_states;
        logic [COUNT_W-1:0]    pressed_count;
        logic                  scan_done;
        logic                  status;
    } t_result;

    // active-low drive pattern, all high for rows without a drive bit
    function automatic logic [DRIVE_W-1:0] drive_pattern(input logic [3:0] row);
        logic [DRIVE_W-1:0] pat;
        if (row >= 4'(DRIVE_W)) begin
            pat = '1;
        end else begin
            pat = ~(DRIVE_W'(1) << row[1:0]);
        end
        return pat;
    endfunction

    // key class transition for one sample
    function automatic t_key_class next_class(input t_key_class prev, input logic down);
        t_key_class nc;
        if (down) begin
            nc = (prev == KC_IDLE || prev == KC_RELEASED) ? KC_PRESSED : KC_HELD;
        end else begin
            nc = (prev == KC_PRESSED || prev == KC_HELD) ? KC_RELEASED : KC_IDLE;
        end
        return nc;
    endfunction

endpackage

`default_nettype wire

[rtl/keypad_matrix_scanner_core.sv]
// top level of the keypad matrix scanner: handshakes, register port, result register
`default_nettype none

// Scans a key matrix one row per transfer. The block keeps a row counter;
// each input transfer carries the active-low column levels sampled while
// that row was driven low, and the result tells which row it was, the drive
// pattern to apply for the next sample, the new class of the row's keys
// (idle, just pressed, held, just released), the classes of all keys, and,
// on the transfer that completes the last row, the number of keys found
// down during the scan. Software sets the enable register (address 0, bit 0)
// once the pins are set up; while it is clear every transfer is answered
// with a not-enabled status and no state changes. Only write it while no
// transfer is in flight. Throughput is one transfer per clock unless the
// output stalls: the input register feeds a single pass of row update
// logic whose result and state updates are written at the same edge into
// the result register and the key class flops, so the next row already
// sees the new state. A transfer waits in the input register until the
// result register is free, then its result is written there. The output
// and input registers together let a new transfer enter while a result waits.
module keypad_matrix_scanner_core #(
    parameter int ROW_COUNT    = kms_pkg::ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = kms_pkg::COLUMN_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [kms_pkg::LEVELS_W-1:0]    i_column_levels,

    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [kms_pkg::ROW_OUT_W-1:0]   o_row_scanned,
    output logic [kms_pkg::DRIVE_W-1:0]     o_next_row_drive,
    output logic [kms_pkg::ROW_KEYS_W-1:0]  o_row_key_states,
    output logic [kms_pkg::ALL_KEYS_W-1:0]  o_all_key_states,
    output logic [kms_pkg::COUNT_W-1:0]     o_pressed_count,
    output logic                            o_scan_done,
    output logic                            o_status,

    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kms_pkg::PADDR_W-1:0]     paddr,
    input  logic [kms_pkg::PDATA_W-1:0]     pwdata,
    output logic [kms_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    // input register
    logic                           r_in_valid;
    logic [kms_pkg::LEVELS_W-1:0]   r_in_levels;

    // result register
    logic                           r_out_valid;
    kms_pkg::t_result               r_out;

    // enable register
    logic                           r_enabled;

    logic                           out_free;
    logic                           advance;
    logic                           in_take;
    logic                           reg_write;
    kms_pkg::t_result               result;

    // result register can load when empty or being drained this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    kms_scan_state #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_scan_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_levels  (r_in_levels),
        .i_enabled (r_enabled),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_levels <= i_column_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_row_scanned    = r_out.row_scanned;
    assign o_next_row_drive = r_out.next_row_drive;
    assign o_row_key_states = r_out.row_key_states;
    assign o_all_key_states = r_out.all_key_states;
    assign o_pressed_count  = r_out.pressed_count;
    assign o_scan_done      = r_out.scan_done;
    assign o_status         = r_out.status;

    // register port: no wait states, word index is paddr[2]
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == kms_pkg::REG_SCANNER_ENABLED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
        end else if (reg_write) begin
            r_enabled <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == kms_pkg::REG_SCANNER_ENABLED) ?
                    kms_pkg::PDATA_W'(r_enabled) : '0;

`ifndef SYNTHESIS
    // a not-enabled answer carries no row classes and no scan completion
    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> !o_scan_done && o_row_key_states == '0)
        else $error("refused transfer carries update data");

    // the count is only reported with the end of a scan
    a_count_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_scan_done |-> o_pressed_count == '0)
        else $error("pressed count outside scan end");

    // a finished scan restarts at the first row
    a_wrap_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scan_done |-> o_next_row_drive == kms_pkg::drive_pattern(4'd0))
        else $error("scan end does not drive first row");

    // an item leaving the input register shows up as a result next cycle
    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("advanced item lost");
`endif

endmodule

`default_nettype wire

[rtl/kms_row_update.sv]
// class update and down count for the keys of one scanned row
`default_nettype none

module kms_row_update #(
    parameter int COLUMN_COUNT = kms_pkg::COLUMN_COUNT_DEF
) (
    input  logic [2*COLUMN_COUNT-1:0]         i_prev,
    input  logic [kms_pkg::LEVELS_W-1:0]      i_levels,
    output logic [2*COLUMN_COUNT-1:0]         o_next,
    output logic [kms_pkg::DOWN_CNT_W-1:0]    o_down_count
);

    localparam int CntCols = (COLUMN_COUNT < kms_pkg::LEVELS_W) ?
                             COLUMN_COUNT : kms_pkg::LEVELS_W;

    logic [COLUMN_COUNT-1:0] down;

    for (genvar c = 0; c < COLUMN_COUNT; c++) begin : g_col
        if (c < kms_pkg::LEVELS_W) begin : g_wired
            assign down[c] = ~i_levels[c];
        end else begin : g_open
            // no column line: reads high
            assign down[c] = 1'b0;
        end
        assign o_next[2*c +: 2] = kms_pkg::next_class(
            kms_pkg::t_key_class'(i_prev[2*c +: 2]), down[c]);
    end

    always_comb begin
        o_down_count = '0;
        for (int c = 0; c < CntCols; c++) begin
            o_down_count = o_down_count + kms_pkg::DOWN_CNT_W'(down[c]);
        end
    end

endmodule

`default_nettype wire

[rtl/kms_scan_state.sv]
// key class store, row counter, scan count and result formation
`default_nettype none

module kms_scan_state #(
    parameter int ROW_COUNT    = kms_pkg::ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = kms_pkg::COLUMN_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [kms_pkg::LEVELS_W-1:0]  i_levels,
    input  logic                          i_enabled,
    output kms_pkg::t_result              o_result
);

    localparam int RowW  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int KeyN  = ROW_COUNT * COLUMN_COUNT;
    localparam int SumW  = kms_pkg::COUNT_W + 1;
    localparam int SatMax = (1 << kms_pkg::COUNT_W) - 1;

    logic [2*COLUMN_COUNT-1:0]       r_class [ROW_COUNT];
    logic [RowW-1:0]                 r_row;
    logic [kms_pkg::COUNT_W-1:0]     r_running;

    logic [2*COLUMN_COUNT-1:0]       cur_row;
    logic [2*COLUMN_COUNT-1:0]       new_row;
    logic [kms_pkg::DOWN_CNT_W-1:0]  down_cnt;
    logic                            last;
    logic [RowW-1:0]                 n_row;
    logic [SumW-1:0]                 sum;
    logic [kms_pkg::COUNT_W-1:0]     sat;
    logic [RowW+1:0]                 row_wide;
    logic [kms_pkg::ROW_KEYS_W-1:0]  row_keys;
    logic [kms_pkg::ALL_KEYS_W-1:0]  all_keys;

    assign cur_row = r_class[r_row];

    kms_row_update #(
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_row_update (
        .i_prev       (cur_row),
        .i_levels     (i_levels),
        .o_next       (new_row),
        .o_down_count (down_cnt)
    );

    assign last  = (r_row == RowW'(ROW_COUNT - 1));
    assign n_row = last ? '0 : r_row + RowW'(1);
    assign sum   = SumW'(r_running) + SumW'(down_cnt);
    assign sat   = (sum > SumW'(SatMax)) ? kms_pkg::COUNT_W'(SatMax) : sum[kms_pkg::COUNT_W-1:0];

    // first four keys of the row
    for (genvar c = 0; c < kms_pkg::ROW_KEYS_MAX; c++) begin : g_row_keys
        if (c < COLUMN_COUNT) begin : g_key
            assign row_keys[2*c +: 2] = new_row[2*c +: 2];
        end else begin : g_none
            assign row_keys[2*c +: 2] = 2'b00;
        end
    end

    // first sixteen keys, current row taken from the update when enabled
    for (genvar k = 0; k < kms_pkg::ALL_KEYS_MAX; k++) begin : g_all_keys
        if (k < KeyN) begin : g_key
            localparam int KR = k / COLUMN_COUNT;
            localparam int KC = k % COLUMN_COUNT;
            assign all_keys[2*k +: 2] = (i_enabled && r_row == RowW'(KR)) ?
                                        new_row[2*KC +: 2] : r_class[KR][2*KC +: 2];
        end else begin : g_none
            assign all_keys[2*k +: 2] = 2'b00;
        end
    end

    assign row_wide = {2'b00, r_row};

    always_comb begin
        o_result.row_scanned    = row_wide[1:0];
        o_result.all_key_states = all_keys;
        if (i_enabled) begin
            o_result.next_row_drive = kms_pkg::drive_pattern(4'(n_row));
            o_result.row_key_states = row_keys;
            o_result.pressed_count  = last ? sat : '0;
            o_result.scan_done      = last;
            o_result.status         = kms_pkg::STATUS_OK;
        end else begin
            o_result.next_row_drive = kms_pkg::drive_pattern(4'(r_row));
            o_result.row_key_states = '0;
            o_result.pressed_count  = '0;
            o_result.scan_done      = 1'b0;
            o_result.status         = kms_pkg::STATUS_NOT_ENABLED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_running <= '0;
            for (int r = 0; r < ROW_COUNT; r++) begin
                r_class[r] <= {COLUMN_COUNT{kms_pkg::KC_IDLE}};
            end
        end else if (i_advance && i_enabled) begin
            r_row          <= n_row;
            r_running      <= last ? '0 : sat;
            r_class[r_row] <= new_row;
        end
    end

endmodule

`default_nettype wire
